// File: src/gbn_pkg.sv
package gbn_pkg;

    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [2:0] ST_SENT      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_ADVANCED  = 3'd2;
    localparam logic [2:0] ST_IGNORED   = 3'd3;
    localparam logic [2:0] ST_RETRANS   = 3'd4;
    localparam logic [2:0] ST_NOTHING   = 3'd5;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] ack_seqno;
        logic [15:0] segment_length;
        logic [31:0] segment_ref;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        tx_valid;
        logic [31:0] tx_seqno;
        logic [15:0] tx_length;
        logic [31:0] tx_ref;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] length;
        logic [31:0] buf_ref;
    } desc_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_RTX
    } state_t;

endpackage

// File: src/gbn_slot_ram.sv
module gbn_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic               clk,
    input  gbn_pkg::ram_ctl_t  ctl,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  gbn_pkg::desc_t     wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output gbn_pkg::desc_t     rd_data
);

    gbn_pkg::desc_t mem [DEPTH];
    gbn_pkg::desc_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/gbn_ctrl.sv
module gbn_ctrl #(
    parameter int WINDOW_DEPTH = 16,
    parameter int SLOT_W       = 4,
    parameter int CNT_W        = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  gbn_pkg::item_t     item,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    output gbn_pkg::ram_ctl_t  ram_ctl,
    output logic [SLOT_W-1:0]  wr_addr,
    output gbn_pkg::desc_t     wr_data,
    output logic [SLOT_W-1:0]  rd_addr,
    input  gbn_pkg::desc_t     rd_data,
    output logic               result_strobe,
    output gbn_pkg::result_t   result
);

    localparam int LW = 9;
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [LW-1:0]     DEPTH_L  = LW'(WINDOW_DEPTH);

    gbn_pkg::state_t   state_reg, state_next;
    logic [4:0]        limit_reg, limit_next;
    logic [31:0]       base_reg, base_next;
    logic [31:0]       next_reg, next_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] base_slot_reg, base_slot_next;
    logic [SLOT_W-1:0] next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [31:0]       rd_seq_reg, rd_seq_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              strobe_reg, strobe_next;
    logic              from_ram_reg, from_ram_next;
    gbn_pkg::result_t  res_reg, res_next;

    logic              accept;
    logic [LW-1:0]     limit_l;
    logic [LW-1:0]     eff_limit;
    logic              window_full;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        if (s == SLOT_MAX)
            return '0;
        else
            return s + SLOT_W'(1);
    endfunction

    assign busy   = (state_reg != gbn_pkg::S_IDLE);
    assign accept = start && !busy;

    // clamp the limit to 1..depth
    always_comb
    begin
        limit_l = LW'(limit_reg);
        if (limit_l == '0)
            eff_limit = LW'(1);
        else if (limit_l > DEPTH_L)
            eff_limit = DEPTH_L;
        else
            eff_limit = limit_l;
    end

    assign window_full = (LW'(count_reg) >= eff_limit);

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        base_next      = base_reg;
        next_next      = next_reg;
        count_next     = count_reg;
        base_slot_next = base_slot_reg;
        next_slot_next = next_slot_reg;
        rd_slot_next   = rd_slot_reg;
        rd_seq_next    = rd_seq_reg;
        remain_next    = remain_reg;
        strobe_next    = 1'b0;
        from_ram_next  = 1'b0;
        res_next       = '0;
        res_next.last  = 1'b1;
        ram_ctl        = '0;

        if (cfg_we)
            limit_next = cfg_wdata;

        case (state_reg)
            gbn_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        gbn_pkg::CMD_SEND:
                        begin
                            strobe_next = 1'b1;
                            if (window_full)
                            begin
                                res_next.status = gbn_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_ctl.wr_en      = 1'b1;
                                res_next.status    = gbn_pkg::ST_SENT;
                                res_next.tx_valid  = 1'b1;
                                res_next.tx_seqno  = next_reg;
                                res_next.tx_length = item.segment_length;
                                res_next.tx_ref    = item.segment_ref;
                                next_next          = next_reg + 32'd1;
                                next_slot_next     = slot_inc(next_slot_reg);
                                count_next         = count_reg + CNT_W'(1);
                            end
                        end
                        gbn_pkg::CMD_ACK:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg != '0 && item.ack_seqno == base_reg)
                            begin
                                res_next.status = gbn_pkg::ST_ADVANCED;
                                base_next       = base_reg + 32'd1;
                                base_slot_next  = slot_inc(base_slot_reg);
                                count_next      = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res_next.status = gbn_pkg::ST_IGNORED;
                            end
                        end
                        gbn_pkg::CMD_TIMEOUT:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next     = 1'b1;
                                res_next.status = gbn_pkg::ST_NOTHING;
                            end
                            else
                            begin
                                state_next   = gbn_pkg::S_RTX;
                                rd_slot_next = base_slot_reg;
                                rd_seq_next  = base_reg;
                                remain_next  = count_reg;
                            end
                        end
                        default:
                        begin
                            // unused command: no beat
                        end
                    endcase
                end
            end
            gbn_pkg::S_RTX:
            begin
                // one slot read per cycle, its data appears with the beat
                ram_ctl.rd_en     = 1'b1;
                strobe_next       = 1'b1;
                from_ram_next     = 1'b1;
                res_next.status   = gbn_pkg::ST_RETRANS;
                res_next.tx_valid = 1'b1;
                res_next.tx_seqno = rd_seq_reg;
                res_next.last     = (remain_reg == CNT_W'(1));
                rd_slot_next      = slot_inc(rd_slot_reg);
                rd_seq_next       = rd_seq_reg + 32'd1;
                remain_next       = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                    state_next = gbn_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gbn_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbn_pkg::S_IDLE;
            limit_reg     <= gbn_pkg::LIMIT_RESET;
            base_reg      <= '0;
            next_reg      <= '0;
            count_reg     <= '0;
            base_slot_reg <= '0;
            next_slot_reg <= '0;
            rd_slot_reg   <= '0;
            rd_seq_reg    <= '0;
            remain_reg    <= '0;
            strobe_reg    <= 1'b0;
            from_ram_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            count_reg     <= count_next;
            base_slot_reg <= base_slot_next;
            next_slot_reg <= next_slot_next;
            rd_slot_reg   <= rd_slot_next;
            rd_seq_reg    <= rd_seq_next;
            remain_reg    <= remain_next;
            strobe_reg    <= strobe_next;
            from_ram_reg  <= from_ram_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign wr_addr         = next_slot_reg;
    assign wr_data.length  = item.segment_length;
    assign wr_data.buf_ref = item.segment_ref;
    assign rd_addr         = rd_slot_reg;

    always_comb
    begin
        result = res_reg;
        if (from_ram_reg)
        begin
            result.tx_length = rd_data.length;
            result.tx_ref    = rd_data.buf_ref;
        end
    end

    assign result_strobe = strobe_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("outstanding count above window depth");

    a_seq_span: assert property (@(posedge clk) disable iff (!rst_n)
        (next_reg - base_reg) == 32'(count_reg))
        else $error("sequence span disagrees with outstanding count");

    a_rtx_beat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gbn_pkg::S_RTX |=> strobe_reg && res_reg.status == gbn_pkg::ST_RETRANS)
        else $error("retransmit cycle without a beat");

    a_timeout_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.command == gbn_pkg::CMD_TIMEOUT && count_reg != '0 |=> busy)
        else $error("timeout with outstanding segments did not start a walk");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !res_reg.tx_valid |-> res_reg.tx_seqno == '0 && !from_ram_reg)
        else $error("non-transmit beat carries segment data");

endmodule

// File: src/go_back_n_sender_window_top.sv
// Go-Back-N sender window. An item is taken when start is high and busy is low;
// each result beat is on result for exactly one cycle with result_strobe high, and
// the receiver cannot stall, so it must take every beat as it comes. A send or an
// ack gives its single beat the cycle after it is taken and keeps busy low, so
// such commands can be issued every cycle. A timeout with N segments outstanding
// walks the descriptor memory through its single read port, one slot per cycle:
// busy stays high during the walk and the N beats come one per cycle, the first
// one once S_RTX has read its slot into the memory's read register, the final
// one flagged by last; the next item can be taken in the cycle of that final
// beat. A timeout with nothing outstanding, like a send or an ack, gives a
// single beat. The user writes window_limit through cfg_we/cfg_wdata only while
// no walk is running (the block itself does not enforce it); it resets to 16.
module go_back_n_sender_window_top #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gbn_pkg::item_t    item,
    input  logic              cfg_we,
    input  logic [4:0]        cfg_wdata,
    output logic              result_strobe,
    output gbn_pkg::result_t  result
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);

    gbn_pkg::ram_ctl_t  ram_ctl;
    logic [SLOT_W-1:0]  wr_addr;
    logic [SLOT_W-1:0]  rd_addr;
    gbn_pkg::desc_t     wr_data;
    gbn_pkg::desc_t     rd_data;

    gbn_slot_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbn_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SLOT_W       (SLOT_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .ram_ctl       (ram_ctl),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// File: tb/sv/tb_go_back_n_sender_window_top.sv
`timescale 1ns / 100ps

module tb_go_back_n_sender_window_top;

    localparam int DEPTH = 16;
    localparam int PHASE_ITEMS = 56;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // predicts the result beats of the sender window and checks them in order
    class gbn_tx_tracker;
        logic [31:0] base;
        logic [31:0] next_seq;
        logic [4:0]  limit;
        logic [15:0] slot_len [DEPTH];
        logic [31:0] slot_buf [DEPTH];
        gbn_pkg::result_t expected_beats [$];
        int          errors;
        int          beats_seen;

        function new();
            base = 0;
            next_seq = 0;
            limit = gbn_pkg::LIMIT_RESET;
            errors = 0;
            beats_seen = 0;
        endfunction

        function int eff_limit();
            if (limit == 0)
                return 1;
            if (limit > DEPTH)
                return DEPTH;
            return int'(limit);
        endfunction

        function void push_beat(logic [2:0] st, logic vld, logic [31:0] seq,
                                logic [15:0] len, logic [31:0] seg_buf, logic lst);
            gbn_pkg::result_t r;
            r.status = st;
            r.tx_valid = vld;
            r.tx_seqno = seq;
            r.tx_length = len;
            r.tx_ref = seg_buf;
            r.last = lst;
            expected_beats.push_back(r);
        endfunction

        function void set_limit(logic [4:0] v);
            limit = v;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void note_command(gbn_pkg::item_t it);
            logic [31:0] outstanding;
            logic [31:0] seq;
            int          n;
            outstanding = next_seq - base;
            case (it.command)
                gbn_pkg::CMD_SEND:
                begin
                    if (outstanding >= eff_limit())
                    begin
                        push_beat(gbn_pkg::ST_FULL, 1'b0, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        slot_len[next_seq % DEPTH] = it.segment_length;
                        slot_buf[next_seq % DEPTH] = it.segment_ref;
                        push_beat(gbn_pkg::ST_SENT, 1'b1, next_seq, it.segment_length,
                                  it.segment_ref, 1'b1);
                        next_seq = next_seq + 1;
                    end
                end
                gbn_pkg::CMD_ACK:
                begin
                    if (outstanding != 0 && it.ack_seqno == base)
                    begin
                        base = base + 1;
                        push_beat(gbn_pkg::ST_ADVANCED, 1'b0, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        push_beat(gbn_pkg::ST_IGNORED, 1'b0, '0, '0, '0, 1'b1);
                    end
                end
                gbn_pkg::CMD_TIMEOUT:
                begin
                    if (outstanding == 0)
                    begin
                        push_beat(gbn_pkg::ST_NOTHING, 1'b0, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        n = (outstanding > DEPTH) ? DEPTH : int'(outstanding);
                        for (int i = 0; i < n; i++)
                        begin
                            seq = base + i;
                            push_beat(gbn_pkg::ST_RETRANS, 1'b1, seq, slot_len[seq % DEPTH],
                                      slot_buf[seq % DEPTH], (i == n - 1));
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_beat(gbn_pkg::result_t got);
            gbn_pkg::result_t exp;
            string   bad;
            bad = "";
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                report($sformatf("beat %0d not expected, got %h", beats_seen, got));
            end
            else
            begin
                exp = expected_beats.pop_front();
                if (got.status !== exp.status)
                    bad = {bad, " status"};
                if (got.tx_valid !== exp.tx_valid)
                    bad = {bad, " tx_valid"};
                if (got.tx_seqno !== exp.tx_seqno)
                    bad = {bad, " tx_seqno"};
                if (got.tx_length !== exp.tx_length)
                    bad = {bad, " tx_length"};
                if (got.tx_ref !== exp.tx_ref)
                    bad = {bad, " tx_ref"};
                if (got.last !== exp.last)
                    bad = {bad, " last"};
                if (bad != "")
                    report($sformatf("beat %0d wrong:%s, got %h expected %h",
                                     beats_seen, bad, got, exp));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    gbn_pkg::item_t   item;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        result_strobe;
    gbn_pkg::result_t result;

    gbn_tx_tracker tracker;

    go_back_n_sender_window_top #(
        .WINDOW_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .result_strobe(result_strobe),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            tracker.check_beat(result);
    end

    // presents one command and returns at the edge that takes it; start stays high
    task issue(gbn_pkg::item_t it);
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        tracker.note_command(it);
    endtask

    task idle(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic gbn_pkg::item_t make_item(logic [1:0] cmd, logic [31:0] ack,
                                                 logic [15:0] len, logic [31:0] seg_buf);
        gbn_pkg::item_t it;
        it.command = cmd;
        it.ack_seqno = ack;
        it.segment_length = len;
        it.segment_ref = seg_buf;
        return it;
    endfunction

    // mostly well-formed traffic: sends, in-order acks, some stray acks and timeouts
    function automatic gbn_pkg::item_t pick_command();
        gbn_pkg::item_t it;
        int    r;
        it = make_item(gbn_pkg::CMD_SEND, $urandom, 16'($urandom), $urandom);
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            it.command = gbn_pkg::CMD_SEND;
            if ($urandom_range(0, 5) == 0)
                it.segment_length = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            if ($urandom_range(0, 9) == 0)
                it.segment_ref = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        end
        else if (r < 80)
        begin
            it.command = gbn_pkg::CMD_ACK;
            it.ack_seqno = tracker.base;
        end
        else if (r < 87)
        begin
            it.command = gbn_pkg::CMD_ACK;
        end
        else if (r < 92)
        begin
            it.command = gbn_pkg::CMD_ACK;
            case ($urandom_range(0, 2))
                0: it.ack_seqno = tracker.base + 1;
                1: it.ack_seqno = tracker.base - 1;
                default: it.ack_seqno = tracker.next_seq;
            endcase
        end
        else if (r < 97)
        begin
            it.command = gbn_pkg::CMD_TIMEOUT;
        end
        else
        begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    // unused commands give no beat, so wait for the predicted beats, then idle past the last one
    task wait_drained();
        start <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
    endtask

    task write_window_limit(logic [4:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        tracker.set_limit(v);
        cfg_we <= 1'b0;
    endtask

    task run_directed();
        issue(make_item(gbn_pkg::CMD_ACK, 32'h0, 16'h0, 32'h0));
        issue(make_item(gbn_pkg::CMD_TIMEOUT, 32'hffff_ffff, 16'hffff, 32'hffff_ffff));
        issue(make_item(gbn_pkg::CMD_SEND, 32'h0, 16'h0000, 32'h0000_0000));
        issue(make_item(gbn_pkg::CMD_SEND, 32'hffff_ffff, 16'hffff, 32'hffff_ffff));
        issue(make_item(gbn_pkg::CMD_SEND, $urandom, 16'($urandom), $urandom));
        issue(make_item(gbn_pkg::CMD_ACK, 32'd5, 16'h0, 32'h0));
        issue(make_item(gbn_pkg::CMD_ACK, 32'd0, 16'($urandom), $urandom));
        issue(make_item(gbn_pkg::CMD_TIMEOUT, $urandom, 16'($urandom), $urandom));
        issue(make_item(CMD_UNUSED, $urandom, 16'($urandom), $urandom));
        // fill the window to sixteen, then one refused send and a full walk
        for (int i = 0; i < 14; i++)
            issue(make_item(gbn_pkg::CMD_SEND, $urandom, 16'($urandom), $urandom));
        issue(make_item(gbn_pkg::CMD_SEND, $urandom, 16'($urandom), $urandom));
        issue(make_item(gbn_pkg::CMD_TIMEOUT, $urandom, 16'($urandom), $urandom));
    endtask

    task run_random(int count);
        int    n;
        int    burst;
        gbn_pkg::item_t it;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < count; k++)
            begin
                it = pick_command();
                issue(it);
                if (it.command != CMD_UNUSED)
                    n++;
            end
            if ($urandom_range(0, 3) == 0)
                idle(0);
            else
                idle($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        logic [4:0] limits [8];
        limits = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd10, 5'd21, 5'd4, 5'd0};
        limits[7] = 5'($urandom_range(0, 31));
        tracker = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        run_directed();
        foreach (limits[p])
        begin
            write_window_limit(limits[p]);
            run_random(PHASE_ITEMS);
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
